/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Free-form property, clocked on clk_i, off while rst_ni is low
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

/* src/wsfa_pkg.sv */
// ----------------------------------------------------------------------------
// wsfa_pkg
// Shared widths, register codes, reset values and control structs of the
// wheel speed block.
// ----------------------------------------------------------------------------
package wsfa_pkg;

  // Field widths
  localparam int unsigned ANGLE_W    = 14;
  localparam int unsigned GAIN_W     = 18;
  localparam int unsigned THR_W      = 14;
  localparam int unsigned DB_W       = 16;
  localparam int unsigned SPEED_W    = 19;
  localparam int unsigned DELTA_W    = 15;
  localparam int unsigned FRAC_W     = 14;
  localparam int unsigned PROD_W     = DELTA_W + GAIN_W + 1;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = GAIN_W;

  localparam int unsigned HISTORY_TAPS_DEF = 10;

  // Lanes: one per wheel
  localparam int unsigned NUM_LANES  = 2;
  localparam int unsigned LANE_RIGHT = 0;
  localparam int unsigned LANE_LEFT  = 1;

  // One full turn, at unwrap width
  localparam logic signed [DELTA_W:0] TURN_WIDE = 16'sd16384;

  typedef logic signed [SPEED_W-1:0] speed_t;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED_GAIN     = 2'd0,
    CFG_WRAP_THRESHOLD = 2'd1,
    CFG_DEAD_BAND      = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0] speed_gain;
    logic [THR_W-1:0]  wrap_threshold;
    logic [DB_W-1:0]   dead_band;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    speed_gain:     18'd10000,
    wrap_threshold: 14'd13653,
    dead_band:      16'd30
  };

  // Stage loads for a lane
  typedef struct packed {
    logic accept;   // request taken: delta stage and previous angle
    logic load_prod;
    logic load_speed; // history and running sum move
  } lane_ctrl_t;

  // Stage loads for the merge
  typedef struct packed {
    logic load_div;
    logic load_out;
  } merge_ctrl_t;

endpackage

/* src/wsfa_if.sv */
// ----------------------------------------------------------------------------
// wsfa interfaces
// Request channel (angle pair) and result channel (four speeds).
// ----------------------------------------------------------------------------
interface wsfa_in_if;
  import wsfa_pkg::*;

  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] angle_right;
  logic [ANGLE_W-1:0] angle_left;

  modport source (output valid, output angle_right, output angle_left, input ready);
  modport sink   (input valid, input angle_right, input angle_left, output ready);
endinterface

interface wsfa_out_if;
  import wsfa_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] speed_right_now;
  logic signed [SPEED_W-1:0] speed_left_now;
  logic signed [SPEED_W-1:0] speed_right_mean;
  logic signed [SPEED_W-1:0] speed_left_mean;

  modport source (output valid, output speed_right_now, output speed_left_now,
                  output speed_right_mean, output speed_left_mean, input ready);
  modport sink   (input valid, input speed_right_now, input speed_left_now,
                  input speed_right_mean, input speed_left_mean, output ready);
endinterface

/* src/wsfa_lane.sv */
// ----------------------------------------------------------------------------
// wsfa_lane
// One wheel channel: unwrap the angle step, scale to speed, deadband, and
// keep the speed history with its running sum.
// ----------------------------------------------------------------------------
module wsfa_lane #(
  parameter int unsigned HISTORY_TAPS = wsfa_pkg::HISTORY_TAPS_DEF,
  localparam int unsigned SUM_W = wsfa_pkg::SPEED_W + $clog2(HISTORY_TAPS)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  wsfa_pkg::lane_ctrl_t             ctrl_i,
  input  wsfa_pkg::cfg_t                   cfg_i,
  input  logic                             negate_i,
  input  logic [wsfa_pkg::ANGLE_W-1:0]     angle_i,
  output wsfa_pkg::speed_t                 speed_o,
  output logic signed [SUM_W-1:0]          sum_o
);
  import wsfa_pkg::*;

  logic [ANGLE_W-1:0]        last_q;
  logic signed [DELTA_W-1:0] delta_d, delta_q;
  logic signed [PROD_W-1:0]  prod_d, prod_q;
  speed_t                    speed_d;
  speed_t                    hist_q [HISTORY_TAPS];
  logic signed [SUM_W-1:0]   sum_d, sum_q;

  // Angle step, unwrapped by one turn past the threshold
  always_comb begin
    logic signed [DELTA_W:0] diff;
    logic signed [DELTA_W:0] thr;
    logic signed [DELTA_W:0] wrapped;
    diff = $signed({2'b00, angle_i}) - $signed({2'b00, last_q});
    thr  = $signed({2'b00, cfg_i.wrap_threshold});
    if (diff < -thr) begin
      wrapped = diff + TURN_WIDE;
    end else if (diff > thr) begin
      wrapped = diff - TURN_WIDE;
    end else begin
      wrapped = diff;
    end
    delta_d = wrapped[DELTA_W-1:0];
  end

  // Gain multiply
  assign prod_d = delta_q * $signed({1'b0, cfg_i.speed_gain});

  // Floor shift, sign flip, deadband
  always_comb begin
    logic signed [SPEED_W:0] floor_v;
    logic signed [SPEED_W:0] signed_v;
    logic [SPEED_W:0]        mag_v;
    floor_v  = $signed(prod_q[PROD_W-1:FRAC_W]);
    signed_v = negate_i ? -floor_v : floor_v;
    mag_v    = signed_v[SPEED_W] ? unsigned'(-signed_v) : unsigned'(signed_v);
    if (mag_v < {{(SPEED_W + 1 - DB_W){1'b0}}, cfg_i.dead_band}) begin
      speed_d = '0;
    end else begin
      speed_d = signed_v[SPEED_W-1:0];
    end
  end

  // Running sum: newest in, oldest out
  assign sum_d = sum_q
               - {{(SUM_W - SPEED_W){hist_q[HISTORY_TAPS-1][SPEED_W-1]}}, hist_q[HISTORY_TAPS-1]}
               + {{(SUM_W - SPEED_W){speed_d[SPEED_W-1]}}, speed_d};

  // Previous angle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (ctrl_i.accept) begin
      last_q <= angle_i;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      delta_q <= delta_d;
    end
    if (ctrl_i.load_prod) begin
      prod_q <= prod_d;
    end
  end

  // History shift line and sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HISTORY_TAPS; i++) begin
        hist_q[i] <= '0;
      end
      sum_q <= '0;
    end else if (ctrl_i.load_speed) begin
      hist_q[0] <= speed_d;
      for (int i = 1; i < HISTORY_TAPS; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
      sum_q <= sum_d;
    end
  end

  // Newest history entry is the speed stage payload
  assign speed_o = hist_q[0];
  assign sum_o   = sum_q;

endmodule

/* src/wsfa_merge.sv */
// ----------------------------------------------------------------------------
// wsfa_merge
// Joins both lanes into one result: divides each history sum by the tap
// count (reciprocal multiply plus one correction) and holds the result.
// ----------------------------------------------------------------------------
module wsfa_merge #(
  parameter int unsigned HISTORY_TAPS = wsfa_pkg::HISTORY_TAPS_DEF,
  localparam int unsigned SUM_W = wsfa_pkg::SPEED_W + $clog2(HISTORY_TAPS)
) (
  input  logic                    clk_i,
  input  wsfa_pkg::merge_ctrl_t   ctrl_i,
  input  wsfa_pkg::speed_t        speed_i [wsfa_pkg::NUM_LANES],
  input  logic signed [SUM_W-1:0] sum_i   [wsfa_pkg::NUM_LANES],
  output wsfa_pkg::speed_t        now_o   [wsfa_pkg::NUM_LANES],
  output wsfa_pkg::speed_t        mean_o  [wsfa_pkg::NUM_LANES]
);
  import wsfa_pkg::*;

  // floor(2^SUM_W / taps): estimate is at most one below the true quotient
  localparam logic [SUM_W-1:0] RECIP  = SUM_W'((64'd1 << SUM_W) / HISTORY_TAPS);
  localparam logic [SUM_W-1:0] TAPS_V = SUM_W'(HISTORY_TAPS);

  logic                   neg_d  [NUM_LANES];
  logic                   neg_q  [NUM_LANES];
  logic [SUM_W-1:0]       mag_d  [NUM_LANES];
  logic [SUM_W-1:0]       mag_q  [NUM_LANES];
  logic [2*SUM_W-1:0]     prod_d [NUM_LANES];
  logic [2*SUM_W-1:0]     prod_q [NUM_LANES];
  speed_t                 now_q  [NUM_LANES];
  speed_t                 mean_d [NUM_LANES];
  speed_t                 mean_q [NUM_LANES];

  // Magnitude and reciprocal product per lane
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      neg_d[l]  = sum_i[l][SUM_W-1];
      mag_d[l]  = neg_d[l] ? unsigned'(-sum_i[l]) : unsigned'(sum_i[l]);
      prod_d[l] = {{SUM_W{1'b0}}, mag_d[l]} * {{SUM_W{1'b0}}, RECIP};
    end
  end

  // Quotient correction and sign restore
  always_comb begin
    logic [SUM_W-1:0] quo;
    logic [SUM_W-1:0] rem;
    logic [SUM_W-1:0] quo_fix;
    logic [SUM_W-1:0] res;
    for (int l = 0; l < NUM_LANES; l++) begin
      quo       = prod_q[l][2*SUM_W-1:SUM_W];
      rem       = mag_q[l] - SUM_W'(quo * TAPS_V);
      quo_fix   = (rem >= TAPS_V) ? quo + 1'b1 : quo;
      res       = neg_q[l] ? -quo_fix : quo_fix;
      mean_d[l] = res[SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NUM_LANES; l++) begin
      if (ctrl_i.load_div) begin
        neg_q[l]  <= neg_d[l];
        mag_q[l]  <= mag_d[l];
        prod_q[l] <= prod_d[l];
        now_q[l]  <= speed_i[l];
      end
      if (ctrl_i.load_out) begin
        now_o[l]  <= now_q[l];
        mean_q[l] <= mean_d[l];
      end
    end
  end

  assign mean_o = mean_q;

endmodule

/* src/wheel_speed_from_angle.sv */
// ----------------------------------------------------------------------------
// wheel_speed_from_angle
// Wheel speeds and their moving means from a pair of absolute angle sensors.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request per control tick: the raw 14-bit right and left
//   angles. res_o returns one result per request: both instant speeds (right
//   sign flipped, deadband applied) and both means over the last
//   HISTORY_TAPS speeds, truncated toward zero.
//   cfg_we_i/cfg_idx_i/cfg_data_i write speed_gain, wrap_threshold and
//   dead_band; write them only while no request is in flight.
//   A request passes the delta, product, speed, divide and output stages in
//   that order to res_o. Throughput: one request per cycle as long as res_o
//   does not stall; the two wheels run in parallel lanes and the mean divider
//   is a two-stage reciprocal multiply. Each of the five stages holds its item
//   while the next one cannot take it, so when res_o stalls the empty stages
//   still fill; req_i.ready drops only once all five stages hold an item.
//   Reset clears the previous angles, the speed histories, the running sums
//   and all stage valids, and loads the register defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wheel_speed_from_angle #(
  parameter int unsigned HISTORY_TAPS = wsfa_pkg::HISTORY_TAPS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  wsfa_in_if.sink                         req_i,
  wsfa_out_if.source                      res_o,
  input  logic                            cfg_we_i,
  input  logic [wsfa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wsfa_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import wsfa_pkg::*;

  localparam int unsigned SUM_W      = SPEED_W + $clog2(HISTORY_TAPS);
  localparam int unsigned NUM_STAGES = 5;
  localparam int unsigned ST_DELTA   = 0;
  localparam int unsigned ST_PROD    = 1;
  localparam int unsigned ST_SPEED   = 2;
  localparam int unsigned ST_DIV     = 3;
  localparam int unsigned ST_OUT     = 4;

  cfg_t                    cfg_d, cfg_q;
  logic [NUM_STAGES-1:0]   vld_d, vld_q;
  logic [NUM_STAGES-1:0]   take;
  logic                    acc;
  logic                    take_out;
  lane_ctrl_t              lane_ctrl;
  merge_ctrl_t             merge_ctrl;
  speed_t                  lane_speed [NUM_LANES];
  logic signed [SUM_W-1:0] lane_sum   [NUM_LANES];
  speed_t                  now        [NUM_LANES];
  speed_t                  mean       [NUM_LANES];

  // Register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SPEED_GAIN:     cfg_d.speed_gain     = cfg_data_i[GAIN_W-1:0];
        CFG_WRAP_THRESHOLD: cfg_d.wrap_threshold = cfg_data_i[THR_W-1:0];
        CFG_DEAD_BAND:      cfg_d.dead_band      = cfg_data_i[DB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Stage can take an item when empty or when its item moves on
  always_comb begin
    take[ST_OUT] = !vld_q[ST_OUT] || res_o.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      take[k] = !vld_q[k] || take[k+1];
    end
  end

  assign acc      = req_i.valid && take[ST_DELTA];
  assign take_out = res_o.valid && res_o.ready;

  // Stage valids
  always_comb begin
    vld_d[ST_DELTA] = take[ST_DELTA] ? req_i.valid : vld_q[ST_DELTA];
    for (int k = 1; k < NUM_STAGES; k++) begin
      vld_d[k] = take[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Stage loads
  assign lane_ctrl.accept      = acc;
  assign lane_ctrl.load_prod   = take[ST_PROD]  && vld_q[ST_DELTA];
  assign lane_ctrl.load_speed  = take[ST_SPEED] && vld_q[ST_PROD];
  assign merge_ctrl.load_div   = take[ST_DIV]   && vld_q[ST_SPEED];
  assign merge_ctrl.load_out   = take[ST_OUT]   && vld_q[ST_DIV];

  // Right wheel lane (sign flipped)
  wsfa_lane #(
    .HISTORY_TAPS (HISTORY_TAPS)
  ) u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .cfg_i    (cfg_q),
    .negate_i (1'b1),
    .angle_i  (req_i.angle_right),
    .speed_o  (lane_speed[LANE_RIGHT]),
    .sum_o    (lane_sum[LANE_RIGHT])
  );

  // Left wheel lane
  wsfa_lane #(
    .HISTORY_TAPS (HISTORY_TAPS)
  ) u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .cfg_i    (cfg_q),
    .negate_i (1'b0),
    .angle_i  (req_i.angle_left),
    .speed_o  (lane_speed[LANE_LEFT]),
    .sum_o    (lane_sum[LANE_LEFT])
  );

  // Mean divide and result register
  wsfa_merge #(
    .HISTORY_TAPS (HISTORY_TAPS)
  ) u_merge (
    .clk_i   (clk_i),
    .ctrl_i  (merge_ctrl),
    .speed_i (lane_speed),
    .sum_i   (lane_sum),
    .now_o   (now),
    .mean_o  (mean)
  );

  assign req_i.ready            = take[ST_DELTA];
  assign res_o.valid            = vld_q[ST_OUT];
  assign res_o.speed_right_now  = now[LANE_RIGHT];
  assign res_o.speed_left_now   = now[LANE_LEFT];
  assign res_o.speed_right_mean = mean[LANE_RIGHT];
  assign res_o.speed_left_mean  = mean[LANE_LEFT];

  // An empty first stage always takes a request, whatever the output does
  `ASSERT_IMPL(a_ready_when_first_free, !vld_q[ST_DELTA], req_i.ready, "first stage empty but request refused")
  // Requests are refused when every stage is full and the output stalls
  `ASSERT_IMPL(a_full_stall_blocks, (&vld_q) && !res_o.ready, !req_i.ready, "request taken into full pipeline")
  // Items in flight change only by requests in and results out
  `ASSERT_CLK(a_item_count, $past(rst_ni) |-> ($countones(vld_q) == $countones($past(vld_q)) + $past(acc) - $past(take_out)), "items lost or duplicated in pipeline")

endmodule
